// File: rtl/gtc_pkg.sv
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared types, codes and helpers for the three-colourability search core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gtc_pkg;

  localparam logic       ACT_LOAD    = 1'b0;
  localparam logic       ACT_TEST    = 1'b1;
  localparam logic [2:0] ALL_COLOURS = 3'b111;
  localparam logic [1:0] UNCOLOURED  = 2'd3;
  localparam int         NUM_COLOURS = 3;
  localparam logic       CFG_VC_IDX  = 1'b0;
  localparam logic [3:0] VC_RESET    = 4'd13;

  typedef struct packed {
    logic       start;
    logic       out_free;
    logic [3:0] count;
    logic [3:0] skip;
  } search_req_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic colourable;
  } search_sts_t;

  // number of colours left in a candidate set
  function automatic logic [1:0] pop3(input logic [2:0] s);
    case (s)
      3'b000:  pop3 = 2'd0;
      3'b001:  pop3 = 2'd1;
      3'b010:  pop3 = 2'd1;
      3'b100:  pop3 = 2'd1;
      3'b111:  pop3 = 2'd3;
      default: pop3 = 2'd2;
    endcase
  endfunction

endpackage

// File: rtl/gtc_in_if.sv
// ----------------------------------------------------------------------------
// gtc_in_if
// Input item channel: row loads and test requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gtc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  row_index;
  logic [12:0] row_bits;
  logic [3:0]  skip_vertex;

  modport source (output valid, action, row_index, row_bits, skip_vertex, input ready);
  modport sink (input valid, action, row_index, row_bits, skip_vertex, output ready);
endinterface

// File: rtl/gtc_out_if.sv
// ----------------------------------------------------------------------------
// gtc_out_if
// Result item channel: one colourable bit per test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gtc_out_if;
  logic valid;
  logic ready;
  logic colourable;

  modport source (output valid, colourable, input ready);
  modport sink (input valid, colourable, output ready);
endinterface

// File: rtl/gtc_search.sv
// ----------------------------------------------------------------------------
// gtc_search
// Backtracking search engine with forward checking, undo trail memory and
// decision stack memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtc_search #(
  parameter int MAX_VERTICES = 13
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gtc_pkg::search_req_t      req,
  output gtc_pkg::search_sts_t      sts,
  output logic                      adj_rd,
  output logic [$clog2(MAX_VERTICES)-1:0] adj_addr,
  input  logic [MAX_VERTICES-1:0]   adj_row
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int DEPTH = MAX_VERTICES * 12;
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int TAW   = $clog2(DEPTH);
  localparam int TDW   = VW + 3;
  localparam int SD    = MAX_VERTICES + 1;
  localparam int SAW   = $clog2(SD);
  localparam int SW    = $clog2(SD + 1);
  localparam int SDW   = VW + 2 + TW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BUILD  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_UNDO   = 3'd3;
  localparam logic [2:0] ST_CHOOSE = 3'd4;
  localparam logic [2:0] ST_PROP   = 3'd5;
  localparam logic [2:0] ST_POPW   = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic [MAX_VERTICES-1:0] active_r, active_nxt;
  logic [MAX_VERTICES-1:0] nmask_r, nmask_nxt;
  logic [MAX_VERTICES-1:0] nbr_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] nbr_nxt [MAX_VERTICES];
  logic [1:0]              colour_r [MAX_VERTICES];
  logic [1:0]              colour_nxt [MAX_VERTICES];
  logic [2:0]              cand_r [MAX_VERTICES];
  logic [2:0]              cand_nxt [MAX_VERTICES];
  logic [CW-1:0]           rd_cnt_r, rd_cnt_nxt;
  logic                    pend_r;
  logic [VW-1:0]           pend_idx_r;
  logic [CW-1:0]           i_r, i_nxt;
  logic [2:0]              best_r, best_nxt;
  logic [VW-1:0]           pick_r, pick_nxt;
  logic                    found_r, found_nxt;
  logic [TW-1:0]           top_r, top_nxt;
  logic [SW-1:0]           sp_r, sp_nxt;
  logic [VW-1:0]           x_r, x_nxt;
  logic [1:0]              nc_r, nc_nxt;
  logic [1:0]              c_r, c_nxt;
  logic [TW-1:0]           mark_r, mark_nxt;
  logic                    res_r, res_nxt;
  logic                    tr_pend_r, tr_pend_nxt;

  // trail and stack memories
  logic [TDW-1:0] trail_mem [DEPTH];
  logic [TDW-1:0] tr_q;
  logic           tw_en;
  logic [TAW-1:0] tw_addr;
  logic [TDW-1:0] tw_data;
  logic [TAW-1:0] tr_addr;

  logic [SDW-1:0] stk_mem [SD];
  logic [SDW-1:0] sq;
  logic           sw_en;
  logic [SAW-1:0] sw_addr;
  logic [SDW-1:0] sw_data;
  logic [SAW-1:0] sr_addr;

  assign adj_rd   = (state_r == ST_BUILD) && (rd_cnt_r < n_r);
  assign adj_addr = rd_cnt_r[VW-1:0];

  assign sts.idle       = (state_r == ST_IDLE);
  assign sts.done       = (state_r == ST_FIN) && req.out_free;
  assign sts.colourable = res_r;

  always_comb begin
    logic [MAX_VERTICES-1:0] row;
    logic [VW-1:0]           iv;
    logic [1:0]              pc;
    logic                    stop;
    logic [2:0]              cx;
    logic [1:0]              cs;
    logic                    fnd;
    logic [SW-1:0]           sp_dec;
    logic [SW-1:0]           sp_rd;
    logic [SW-1:0]           sp_wr;
    logic [TW-1:0]           top_dec;
    logic [2:0]              m;
    logic [2:0]              newc;
    logic                    nb;

    state_nxt   = state_r;
    n_nxt       = n_r;
    active_nxt  = active_r;
    nmask_nxt   = nmask_r;
    nbr_nxt     = nbr_r;
    colour_nxt  = colour_r;
    cand_nxt    = cand_r;
    rd_cnt_nxt  = rd_cnt_r;
    i_nxt       = i_r;
    best_nxt    = best_r;
    pick_nxt    = pick_r;
    found_nxt   = found_r;
    top_nxt     = top_r;
    sp_nxt      = sp_r;
    x_nxt       = x_r;
    nc_nxt      = nc_r;
    c_nxt       = c_r;
    mark_nxt    = mark_r;
    res_nxt     = res_r;
    tr_pend_nxt = 1'b0;
    tw_en       = 1'b0;
    tw_addr     = top_r[TAW-1:0];
    tw_data     = '0;
    tr_addr     = '0;
    sw_en       = 1'b0;
    sw_addr     = '0;
    sw_data     = '0;
    sr_addr     = '0;
    row         = adj_row & nmask_r;
    iv          = i_r[VW-1:0];
    pc          = gtc_pkg::pop3(cand_r[iv]);
    stop        = 1'b0;
    cx          = cand_r[x_r];
    cs          = 2'd0;
    fnd         = 1'b0;
    sp_dec      = sp_r - SW'(1);
    sp_rd       = sp_dec - SW'(1);
    sp_wr       = sp_r - SW'(1);
    top_dec     = top_r - TW'(1);
    m           = 3'b001 << c_r;
    newc        = cand_r[iv] & ~m;
    nb          = nbr_r[x_r][iv] && active_r[iv] && (iv != x_r);

    // restore one candidate set from the trail
    if (tr_pend_r) begin
      cand_nxt[tr_q[TDW-1:3]] = tr_q[2:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          if (int'(req.count) > MAX_VERTICES) begin
            n_nxt = CW'(MAX_VERTICES);
          end else begin
            n_nxt = CW'(req.count);
          end
          for (int k = 0; k < MAX_VERTICES; k++) begin
            nmask_nxt[k]  = (CW'(k) < n_nxt);
            active_nxt[k] = (CW'(k) < n_nxt) && (4'(k) != req.skip);
            nbr_nxt[k]    = '0;
            colour_nxt[k] = gtc_pkg::UNCOLOURED;
            cand_nxt[k]   = gtc_pkg::ALL_COLOURS;
          end
          top_nxt    = '0;
          sp_nxt     = '0;
          rd_cnt_nxt = '0;
          state_nxt  = ST_BUILD;
        end
      end

      ST_BUILD: begin
        // symmetric neighbor sets from each row as it returns
        if (pend_r) begin
          nbr_nxt[pend_idx_r] = nbr_r[pend_idx_r] | row;
          for (int j = 0; j < MAX_VERTICES; j++) begin
            if (row[j]) begin
              nbr_nxt[j][pend_idx_r] = 1'b1;
            end
          end
        end
        if (rd_cnt_r < n_r) begin
          rd_cnt_nxt = rd_cnt_r + CW'(1);
        end else if (!pend_r) begin
          i_nxt     = '0;
          best_nxt  = 3'd4;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (i_r < n_r) begin
          if (active_r[iv] && (colour_r[iv] == gtc_pkg::UNCOLOURED) &&
              ({1'b0, pc} < best_r)) begin
            best_nxt  = {1'b0, pc};
            pick_nxt  = iv;
            found_nxt = 1'b1;
            if (pc <= 2'd1) begin
              stop = 1'b1;
            end
          end
          i_nxt = i_r + CW'(1);
        end else begin
          stop = 1'b1;
        end
        if (stop) begin
          if (!found_nxt) begin
            res_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else if (sp_r > SW'(MAX_VERTICES)) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            sw_en     = 1'b1;
            sw_addr   = sp_r[SAW-1:0];
            sw_data   = {pick_nxt, 2'd0, top_r};
            sp_nxt    = sp_r + SW'(1);
            x_nxt     = pick_nxt;
            nc_nxt    = 2'd0;
            mark_nxt  = top_r;
            state_nxt = ST_UNDO;
          end
        end
      end

      ST_UNDO: begin
        if (top_r != mark_r) begin
          tr_addr     = top_dec[TAW-1:0];
          top_nxt     = top_dec;
          tr_pend_nxt = 1'b1;
        end else begin
          state_nxt = ST_CHOOSE;
        end
      end

      ST_CHOOSE: begin
        for (int c = 0; c < gtc_pkg::NUM_COLOURS; c++) begin
          if (!fnd && (2'(c) >= nc_r) && cx[c]) begin
            cs  = 2'(c);
            fnd = 1'b1;
          end
        end
        if (fnd) begin
          colour_nxt[x_r] = cs;
          sw_en     = 1'b1;
          sw_addr   = sp_wr[SAW-1:0];
          sw_data   = {x_r, cs + 2'd1, mark_r};
          nc_nxt    = cs + 2'd1;
          c_nxt     = cs;
          i_nxt     = '0;
          state_nxt = ST_PROP;
        end else begin
          colour_nxt[x_r] = gtc_pkg::UNCOLOURED;
          sp_nxt = sp_dec;
          if (sp_dec == '0) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            sr_addr   = sp_rd[SAW-1:0];
            state_nxt = ST_POPW;
          end
        end
      end

      ST_POPW: begin
        x_nxt     = sq[SDW-1 -: VW];
        nc_nxt    = sq[TW+1:TW];
        mark_nxt  = sq[TW-1:0];
        state_nxt = ST_UNDO;
      end

      ST_PROP: begin
        if (i_r < n_r) begin
          if (nb && (colour_r[iv] == gtc_pkg::UNCOLOURED) && ((cand_r[iv] & m) != 3'b000)) begin
            cand_nxt[iv] = newc;
            if (top_r < TW'(DEPTH)) begin
              tw_en   = 1'b1;
              tw_data = {iv, cand_r[iv]};
              top_nxt = top_r + TW'(1);
            end
            if (newc == 3'b000) begin
              state_nxt = ST_UNDO;
            end
          end
          i_nxt = i_r + CW'(1);
        end else begin
          i_nxt     = '0;
          best_nxt  = 3'd4;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_FIN: begin
        if (req.out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pend_r    <= 1'b0;
      tr_pend_r <= 1'b0;
      top_r     <= '0;
      sp_r      <= '0;
      res_r     <= 1'b0;
      for (int k = 0; k < MAX_VERTICES; k++) begin
        colour_r[k] <= gtc_pkg::UNCOLOURED;
        cand_r[k]   <= gtc_pkg::ALL_COLOURS;
      end
    end else begin
      state_r   <= state_nxt;
      pend_r    <= adj_rd;
      tr_pend_r <= tr_pend_nxt;
      top_r     <= top_nxt;
      sp_r      <= sp_nxt;
      res_r     <= res_nxt;
      colour_r  <= colour_nxt;
      cand_r    <= cand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    active_r   <= active_nxt;
    nmask_r    <= nmask_nxt;
    nbr_r      <= nbr_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    pend_idx_r <= adj_addr;
    i_r        <= i_nxt;
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    found_r    <= found_nxt;
    x_r        <= x_nxt;
    nc_r       <= nc_nxt;
    c_r        <= c_nxt;
    mark_r     <= mark_nxt;
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      trail_mem[tw_addr] <= tw_data;
    end
    tr_q <= trail_mem[tr_addr];
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      stk_mem[sw_addr] <= sw_data;
    end
    sq <= stk_mem[sr_addr];
  end

  a_trail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TW'(DEPTH))
    else $error("trail pointer beyond trail depth");

  a_undo_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UNDO) |-> (top_r >= mark_r))
    else $error("undo below frame mark");

  a_prop_coloured: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROP) |-> (colour_r[x_r] != gtc_pkg::UNCOLOURED))
    else $error("propagating from an uncoloured vertex");

endmodule

// File: rtl/graph_three_colourability_search_core.sv
// ----------------------------------------------------------------------------
// graph_three_colourability_search_core
// Decides whether the stored graph, less an optional skipped vertex, has a
// proper three-colouring. A load item writes one adjacency row. A test
// item reads the first n rows, then runs a backtracking search: each
// decision scans up to n vertices (one per cycle) for the fewest remaining
// colours, each colour choice propagates over up to n neighbors (one per
// cycle), and backtracking restores one trail entry per cycle from the
// trail memory. A test's run time therefore depends on the data, set by
// the per-vertex scan and propagation loops and the single trail memory
// port; one result item follows each test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_three_colourability_search_core #(
  parameter int MAX_VERTICES = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  gtc_in_if.sink      in_ch,
  gtc_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int VW = $clog2(MAX_VERTICES);

  logic [3:0]              vc_r;
  logic                    in_acc;
  logic                    cfg_wr;
  logic                    out_valid_r;
  logic                    out_data_r;
  gtc_pkg::search_req_t    req;
  gtc_pkg::search_sts_t    sts;
  logic                    adj_rd;
  logic [VW-1:0]           adj_addr;
  logic [MAX_VERTICES-1:0] adj_q;
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_vld_r;
  logic                    load_en;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == gtc_pkg::CFG_VC_IDX) ? {28'd0, vc_r} : 32'd0;

  assign in_ch.ready = sts.idle;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_en     = in_acc && (in_ch.action == gtc_pkg::ACT_LOAD) &&
                       (int'(in_ch.row_index) < MAX_VERTICES);

  assign req.start    = in_acc && (in_ch.action == gtc_pkg::ACT_TEST);
  assign req.out_free = !out_valid_r || out_ch.ready;
  assign req.count    = vc_r;
  assign req.skip     = in_ch.skip_vertex;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.colourable = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r        <= gtc_pkg::VC_RESET;
      out_valid_r <= 1'b0;
      adj_vld_r   <= '0;
    end else begin
      if (cfg_wr && (cfg_paddr[2] == gtc_pkg::CFG_VC_IDX)) begin
        vc_r <= cfg_pwdata[3:0];
      end
      if (sts.done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (load_en) begin
        adj_vld_r[in_ch.row_index[VW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done) begin
      out_data_r <= sts.colourable;
    end
  end

  // adjacency store; rows never written read as empty
  always_ff @(posedge clk) begin
    if (load_en) begin
      adj_mem[in_ch.row_index[VW-1:0]] <= MAX_VERTICES'(in_ch.row_bits);
    end
    if (adj_rd) begin
      adj_q <= adj_vld_r[adj_addr] ? adj_mem[adj_addr] : '0;
    end
  end

  gtc_search #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .sts      (sts),
    .adj_rd   (adj_rd),
    .adj_addr (adj_addr),
    .adj_row  (adj_q)
  );

endmodule
